// ===== src/psc_pkg.sv =====
// Shared constants, register indexes and types of the PID speed controller.
`default_nettype none

package psc_pkg;

    localparam int COUNT_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DUTY_W = 16;
    localparam int SPEED_W = 21;
    localparam int ERR_W = 21;
    localparam int DERR_W = 22;
    localparam int INTEG_W = 40;
    localparam int INTEG_LO_W = 20;
    localparam int SUM_W = 58;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 40;

    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Speed is count * 600 / 28, reduced to count * 150 / 7.
    localparam int SPEED_MUL = 600;
    localparam int SPEED_DIV = 28;
    localparam int SPEED_NUM = SPEED_MUL / 4;
    localparam int SPEED_DEN = SPEED_DIV / 4;
    localparam int PROD_W = 23;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_MUL = (2 ** RECIP_SHIFT + SPEED_DEN - 1) / SPEED_DEN;
    localparam int QPROD_W = 47;
    localparam int SPEED_ABS_MAX = 702171;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 3'd4;

    localparam logic signed [CFG_W-1:0] TARGET_SPEED_RST = 16'sd400;
    localparam logic [CFG_W-1:0] GAIN_P_RST = 16'd5120;
    localparam logic [CFG_W-1:0] GAIN_I_RST = 16'd128;
    localparam logic [CFG_W-1:0] GAIN_D_RST = 16'd256;
    localparam logic [CFG_W-1:0] DUTY_MAX_RST = 16'd1000;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [ERR_W-1:0]   err;
        logic signed [DERR_W-1:0]  derr;
        logic signed [INTEG_W-1:0] integ;
    } psc_err_t;

endpackage

`default_nettype wire

// ===== src/pid_speed_controller.sv =====
// Top level of the PID speed controller with its configuration registers.
// Pipeline: seven register stages lie between a count transfer and its result.
// One count per cycle without back-pressure; integral and previous error update in one stage.
// Back-pressure on the result stream stalls each pipeline stage only once it is full.
// Reset clears all valid flags and the controller state and loads the register defaults.
`default_nettype none

module pid_speed_controller
    import psc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,  // [15:0] encoder_count
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,  // [15:0] pwm_duty, [36:16] measured_speed
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    logic signed [CFG_W-1:0]   target_speed_reg;
    logic [CFG_W-1:0]          gain_p_reg;
    logic [CFG_W-1:0]          gain_i_reg;
    logic [CFG_W-1:0]          gain_d_reg;
    logic [CFG_W-1:0]          duty_max_reg;
    logic                      spd_valid;
    logic                      spd_ready;
    logic signed [SPEED_W-1:0] spd_speed;
    logic                      err_valid;
    logic                      err_ready;
    psc_err_t                  err_data;
    logic [DUTY_W-1:0]         res_duty;
    logic signed [SPEED_W-1:0] res_speed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_speed_reg <= TARGET_SPEED_RST;
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
            duty_max_reg <= DUTY_MAX_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TARGET_SPEED: target_speed_reg <= $signed(cfg_wdata);
                REG_GAIN_P:       gain_p_reg <= cfg_wdata;
                REG_GAIN_I:       gain_i_reg <= cfg_wdata;
                REG_GAIN_D:       gain_d_reg <= cfg_wdata;
                REG_DUTY_MAX:     duty_max_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    psc_speed u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_count  ($signed(s_axis_tdata[COUNT_W-1:0])),
        .out_valid (spd_valid),
        .out_ready (spd_ready),
        .out_speed (spd_speed)
    );

    psc_integ u_integ (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_speed (target_speed_reg),
        .in_valid     (spd_valid),
        .in_ready     (spd_ready),
        .in_speed     (spd_speed),
        .out_valid    (err_valid),
        .out_ready    (err_ready),
        .out_data     (err_data)
    );

    psc_mac #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .duty_max  (duty_max_reg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_data   (err_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_duty  (res_duty),
        .out_speed (res_speed)
    );

    assign m_axis_tdata = {{(TDATA_OUT_W-DUTY_W-SPEED_W){1'b0}}, res_speed, res_duty};

endmodule

`default_nettype wire

// ===== src/psc_speed.sv =====
// Encoder count to speed conversion pipeline: count * 150 / 7, truncated toward zero.
`default_nettype none

module psc_speed
    import psc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COUNT_W-1:0] in_count,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic signed [SPEED_W-1:0]      out_speed
);

    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;
    logic                      rdy1;
    logic                      rdy2;
    logic                      rdy3;
    logic signed [COUNT_W-1:0] count_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [PROD_W-1:0]         prod_next;
    logic                      neg_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SPEED_W-1:0] speed_next;
    logic signed [COUNT_W:0]   cnt_ext;
    logic [COUNT_W:0]          cnt_abs;
    logic [QPROD_W-1:0]        qprod;
    logic [SPEED_W-1:0]        quot;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v3_reg;
    assign out_speed = speed_reg;

    always_comb
    begin
        cnt_ext = {count_reg[COUNT_W-1], count_reg};
        cnt_abs = count_reg[COUNT_W-1] ? (COUNT_W+1)'(-cnt_ext) : (COUNT_W+1)'(cnt_ext);
        prod_next = PROD_W'(cnt_abs * (COUNT_W+1)'(SPEED_NUM));
    end

    // Division by seven as a multiply by the rounded-up reciprocal.
    always_comb
    begin
        qprod = QPROD_W'(prod_reg) * QPROD_W'(RECIP_MUL);
        quot = qprod[RECIP_SHIFT +: SPEED_W];
        speed_next = neg_reg ? -$signed(quot) : $signed(quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            count_reg <= in_count;
        if (rdy2 && v1_reg)
        begin
            prod_reg <= prod_next;
            neg_reg <= count_reg[COUNT_W-1];
        end
        if (rdy3 && v2_reg)
            speed_reg <= speed_next;
    end

endmodule

`default_nettype wire

// ===== src/psc_integ.sv =====
// Error, saturating integral and error difference stage with the controller state.
`default_nettype none

module psc_integ
    import psc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic signed [CFG_W-1:0]   target_speed,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [SPEED_W-1:0] in_speed,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output psc_err_t                       out_data
);

    logic                      valid_reg;
    psc_err_t                  data_reg;
    psc_err_t                  data_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W:0]   integ_sum;
    logic                      take;

    assign in_ready = !valid_reg || out_ready;
    assign take = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb
    begin
        data_next.speed = in_speed;
        data_next.err = ERR_W'(target_speed) - in_speed;
        data_next.derr = DERR_W'(data_next.err) - DERR_W'(prev_err_reg);
        integ_sum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(data_next.err);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
            data_next.integ = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        else
            data_next.integ = integ_sum[INTEG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            prev_err_reg <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (take)
            begin
                prev_err_reg <= data_next.err;
                integ_reg <= data_next.integ;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== src/psc_mac.sv =====
// Gain multiply, controller sum and duty clamp pipeline.
`default_nettype none

module psc_mac
    import psc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CFG_W-1:0]     gain_p,
    input  wire logic [CFG_W-1:0]     gain_i,
    input  wire logic [CFG_W-1:0]     gain_d,
    input  wire logic [CFG_W-1:0]     duty_max,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire psc_err_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DUTY_W-1:0]         out_duty,
    output logic signed [SPEED_W-1:0] out_speed
);

    localparam int PP_P_W = CFG_W + 1 + ERR_W;
    localparam int PP_D_W = CFG_W + 1 + DERR_W;
    localparam int PP_ILO_W = CFG_W + INTEG_LO_W;
    localparam int PP_IHI_W = CFG_W + 1 + INTEG_W - INTEG_LO_W;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;
    logic signed [PP_P_W-1:0]   pp_p_reg;
    logic signed [PP_D_W-1:0]   pp_d_reg;
    logic [PP_ILO_W-1:0]        pp_ilo_reg;
    logic signed [PP_IHI_W-1:0] pp_ihi_reg;
    logic signed [PP_P_W-1:0]   pp_p_next;
    logic signed [PP_D_W-1:0]   pp_d_next;
    logic [PP_ILO_W-1:0]        pp_ilo_next;
    logic signed [PP_IHI_W-1:0] pp_ihi_next;
    logic signed [SPEED_W-1:0]  speed1_reg;
    logic signed [SPEED_W-1:0]  speed2_reg;
    logic signed [SPEED_W-1:0]  speed3_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    sum_sh;
    logic [DUTY_W-1:0]          duty_reg;
    logic [DUTY_W-1:0]          duty_next;
    logic signed [CFG_W:0]      gp_s;
    logic signed [CFG_W:0]      gi_s;
    logic signed [CFG_W:0]      gd_s;

    assign rdy3 = !v3_reg || out_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v3_reg;
    assign out_duty = duty_reg;
    assign out_speed = speed3_reg;

    // The integral product is split into a low unsigned and a high signed half.
    always_comb
    begin
        gp_s = {1'b0, gain_p};
        gi_s = {1'b0, gain_i};
        gd_s = {1'b0, gain_d};
        pp_p_next = gp_s * in_data.err;
        pp_d_next = gd_s * in_data.derr;
        pp_ilo_next = PP_ILO_W'(gain_i) * PP_ILO_W'(in_data.integ[INTEG_LO_W-1:0]);
        pp_ihi_next = gi_s * $signed(in_data.integ[INTEG_W-1:INTEG_LO_W]);
    end

    always_comb
    begin
        sum_next = SUM_W'(pp_p_reg) + SUM_W'(pp_d_reg)
                 + $signed(SUM_W'(pp_ilo_reg))
                 + (SUM_W'(pp_ihi_reg) <<< INTEG_LO_W);
    end

    always_comb
    begin
        sum_sh = sum_reg >>> GAIN_FRAC_BITS;
        if (sum_reg[SUM_W-1] || (sum_reg == '0))
            duty_next = '0;
        else if ((|sum_sh[SUM_W-1:DUTY_W]) || (sum_sh[DUTY_W-1:0] > duty_max))
            duty_next = duty_max;
        else
            duty_next = sum_sh[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            pp_p_reg <= pp_p_next;
            pp_d_reg <= pp_d_next;
            pp_ilo_reg <= pp_ilo_next;
            pp_ihi_reg <= pp_ihi_next;
            speed1_reg <= in_data.speed;
        end
        if (rdy2 && v1_reg)
        begin
            sum_reg <= sum_next;
            speed2_reg <= speed1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            duty_reg <= duty_next;
            speed3_reg <= speed2_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/psc_checker.sv =====
// Port-level assertions for the PID speed controller and their bind.
`default_nettype none

module psc_checker
    import psc_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic [3:0] pending_reg;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 4'(s_xfer) - 4'(m_xfer);
    end

    // Every result transfer has a count transfer before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer |-> (pending_reg != 4'd0))
        else $error("result transfer without a pending count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TDATA_OUT_W-1:DUTY_W+SPEED_W] == '0))
        else $error("result padding bits not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (($signed(m_axis_tdata[DUTY_W +: SPEED_W]) <= SPEED_W'(SPEED_ABS_MAX)) &&
             ($signed(m_axis_tdata[DUTY_W +: SPEED_W]) >= -SPEED_W'(SPEED_ABS_MAX))))
        else $error("measured speed out of range");

endmodule

bind pid_speed_controller psc_checker u_psc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/pid_speed_controller_tb.sv =====
// Self-checking testbench of the PID speed controller: stream driver, monitor and predictor.
module pid_speed_controller_tb;
    import psc_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT = 2000;
    localparam int FEED_DEPTH = 8;
    localparam longint RPM_MUL = 600;
    localparam longint RPM_DIV = 28;
    localparam longint INTEGRAL_HI = (longint'(1) <<< (INTEG_W - 1)) - 1;
    localparam longint INTEGRAL_LO = -INTEGRAL_HI - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_DUTY_MAX + 3'd1;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty;
        logic signed [SPEED_W-1:0] speed;
    } ctrl_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // [15:0] encoder_count
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;        // [15:0] pwm_duty, [36:16] measured_speed
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    logic signed [CFG_W-1:0] cfg_target = TARGET_SPEED_RST;
    logic [CFG_W-1:0]        cfg_kp = GAIN_P_RST;
    logic [CFG_W-1:0]        cfg_ki = GAIN_I_RST;
    logic [CFG_W-1:0]        cfg_kd = GAIN_D_RST;
    logic [CFG_W-1:0]        cfg_duty_max = DUTY_MAX_RST;
    longint                  pid_integral = 0;
    longint                  pid_prev_err = 0;

    logic [COUNT_W-1:0] pending_counts[$];
    ctrl_result_t       expected_results[$];

    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_left = 0;
    int gap_left = 0;
    int counts_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    pid_speed_controller #(
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic ctrl_result_t pid_update(input logic signed [COUNT_W-1:0] count);
        longint       spd;
        longint       err;
        longint       integ;
        longint       sum;
        longint       duty;
        ctrl_result_t r;
        spd = (longint'(count) * RPM_MUL) / RPM_DIV;
        err = longint'(cfg_target) - spd;
        integ = pid_integral + err;
        if (integ > INTEGRAL_HI)
            integ = INTEGRAL_HI;
        if (integ < INTEGRAL_LO)
            integ = INTEGRAL_LO;
        sum = longint'(cfg_kp) * err + longint'(cfg_ki) * integ
            + longint'(cfg_kd) * (err - pid_prev_err);
        if (sum <= 0)
            duty = 0;
        else
        begin
            duty = sum >>> GAIN_FRAC_BITS_DEF;
            if (duty > longint'(cfg_duty_max))
                duty = longint'(cfg_duty_max);
        end
        pid_integral = integ;
        pid_prev_err = err;
        r.duty = duty[DUTY_W-1:0];
        r.speed = spd[SPEED_W-1:0];
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int c;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: c = (int'(cfg_target) * 28) / 600 + int'($urandom_range(8)) - 4;
            5, 6, 7: c = int'($urandom());
            8:
            begin
                case ($urandom_range(3))
                    0: c = -32768;
                    1: c = 32767;
                    2: c = 0;
                    default: c = -1;
                endcase
            end
            default: c = int'($urandom_range(64)) - 32;
        endcase
        return c[COUNT_W-1:0];
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        if ($urandom_range(1) == 0)
            return CFG_W'($urandom_range(1023));
        return CFG_W'($urandom());
    endfunction

    // Sender: holds the data until it is taken, with short random gaps between transfers when source idling is enabled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(pid_update(s_axis_tdata));
                counts_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (src_idle_en && pending_counts.size() != 0 && $urandom_range(4) == 0)
                begin
                    gap_left = $urandom_range(1, 3) - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_counts.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_counts.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts when sink idling is enabled, plus a long hold-off whenever one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (sink_idle_en && $urandom_range(5) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        ctrl_result_t              want;
        logic [DUTY_W-1:0]         got_duty;
        logic signed [SPEED_W-1:0] got_speed;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_duty = m_axis_tdata[DUTY_W-1:0];
            got_speed = m_axis_tdata[DUTY_W+SPEED_W-1:DUTY_W];
            results_seen++;
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Result transfer with nothing expected: duty %0d speed %0d",
                             got_duty, got_speed);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got_duty != want.duty || got_speed != want.speed)
                begin
                    if (mismatches < 10)
                        $display("Result %0d: expected duty %0d speed %0d, got duty %0d speed %0d",
                                 results_seen, want.duty, want.speed, got_duty, got_speed);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (pending_counts.size() == 0 && expected_results.size() == 0 && !s_axis_tvalid))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("[pid_speed_controller] ERROR");
            $finish;
        end
    end

    task automatic queue_count(input logic [COUNT_W-1:0] c);
        while (pending_counts.size() >= FEED_DEPTH)
            @(negedge clk);
        pending_counts.push_back(c);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_counts.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TARGET_SPEED: cfg_target = val;
            REG_GAIN_P: cfg_kp = val;
            REG_GAIN_I: cfg_ki = val;
            REG_GAIN_D: cfg_kd = val;
            REG_DUTY_MAX: cfg_duty_max = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] target, input logic [CFG_W-1:0] kp,
                                  input logic [CFG_W-1:0] ki, input logic [CFG_W-1:0] kd,
                                  input logic [CFG_W-1:0] dmax);
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(2)), CFG_W'($urandom()));
        write_reg(REG_TARGET_SPEED, target);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_DUTY_MAX, dmax);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(input int n, input bit src_idle, input bit sink_idle,
                              input bit hold_off);
        src_idle_en = src_idle;
        sink_idle_en = sink_idle;
        if (hold_off)
            holds_asked++;
        for (int i = 0; i < n; i++)
            queue_count(pick_count());
        wait_drained();
    endtask

    initial
    begin
        logic signed [COUNT_W-1:0] directed[20];
        directed = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd18, 16'sd19,
                     -16'sd19, 16'sd27, 16'sd28, -16'sd28, 16'sh5555, 16'shAAAA, 16'sd100,
                     -16'sd100, 16'sd1000, 16'sd18, 16'sd18, 16'sd19, 16'sd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: extremes of the count, both signs near the setpoint.
        foreach (directed[i])
            queue_count(directed[i]);
        wait_drained();

        run_random(240, 1'b1, 1'b1, 1'b0);
        apply_settings(16'sd32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(240, 1'b0, 1'b1, 1'b1);
        apply_settings(-16'sd32768, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        run_random(200, 1'b1, 1'b1, 1'b0);
        apply_settings(CFG_W'($urandom()), rand_gain(), rand_gain(), rand_gain(), 16'd0);
        run_random(200, 1'b1, 1'b1, 1'b0);
        apply_settings(16'sd0, 16'd256, 16'd0, 16'd0, 16'hFFFF);
        run_random(200, 1'b1, 1'b1, 1'b0);
        apply_settings(CFG_W'($urandom()), rand_gain(), rand_gain(), rand_gain(),
                       CFG_W'($urandom()));
        run_random(240, 1'b1, 1'b1, 1'b0);
        apply_settings(CFG_W'($urandom_range(2000)), rand_gain(), CFG_W'($urandom_range(64)),
                       rand_gain(), CFG_W'($urandom()));
        run_random(240, 1'b1, 1'b1, 1'b0);
        apply_settings(CFG_W'($urandom()), rand_gain(), rand_gain(), rand_gain(),
                       CFG_W'($urandom()));
        run_random(240, 1'b0, 1'b0, 1'b0);
        apply_settings(CFG_W'($urandom()), rand_gain(), 16'hFFFF, rand_gain(), 16'hFFFF);
        run_random(200, 1'b0, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        $display("Checked %0d of %0d count transfers over nine register settings,",
                 results_seen, counts_sent);
        $display("including zero and full gains, a zero duty limit and a long receiver stall.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[pid_speed_controller] OK");
        else
            $display("[pid_speed_controller] ERROR");
        $finish;
    end

endmodule
